### src/nrbp_pkg.sv
// Shared types, constants and helper functions for the nucleotide run block packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nrbp_pkg;

  // Packing and counter geometry
  localparam int WORD_BITS  = 64;
  localparam int OUT_WORD_W = 64;
  localparam int POS_BITS   = 40;
  localparam int SEQ_BITS   = 32;
  localparam int CNT_BITS   = 32;
  localparam int BITPOS_W   = POS_BITS + 1;
  localparam int SLOTS      = WORD_BITS / 2;
  localparam int FILL_W     = 6;
  localparam int SYM_W      = 8;

  // Command queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};
  localparam logic [SEQ_BITS-1:0] SEQ_ALL = {SEQ_BITS{1'b1}};

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // ASCII codes of the four bases
  localparam logic [SYM_W-1:0] SYM_UA = 8'h41;
  localparam logic [SYM_W-1:0] SYM_UC = 8'h43;
  localparam logic [SYM_W-1:0] SYM_UG = 8'h47;
  localparam logic [SYM_W-1:0] SYM_UT = 8'h54;
  localparam logic [SYM_W-1:0] SYM_LA = 8'h61;
  localparam logic [SYM_W-1:0] SYM_LC = 8'h63;
  localparam logic [SYM_W-1:0] SYM_LG = 8'h67;
  localparam logic [SYM_W-1:0] SYM_LT = 8'h74;

  typedef enum logic [1:0] {
    RK_WORD  = 2'd0,
    RK_BLOCK = 2'd1,
    RK_SENT  = 2'd2
  } result_kind_t;

  // Input payload, first field in the highest bits
  typedef struct packed {
    logic [POS_BITS-1:0] str_pos;
    logic [POS_BITS-1:0] pos_in_seq;
    logic [SEQ_BITS-1:0] seq_id;
    logic [SYM_W-1:0]    symbol;
  } in_t;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic [CNT_BITS-1:0]   block_total;
    logic [POS_BITS-1:0]   base_total;
    logic [POS_BITS-1:0]   block_length;
    logic [BITPOS_W-1:0]   block_bit_pos;
    logic [POS_BITS-1:0]   block_stream_offset;
    logic [POS_BITS-1:0]   block_seq_pos;
    logic [SEQ_BITS-1:0]   block_seq;
    logic                  block_is_bases;
    logic [FILL_W-1:0]     packed_count;
    logic [OUT_WORD_W-1:0] packed_word;
  } res_t;

  // One queued command: everything needed to produce the results of one item
  typedef struct packed {
    logic                  has_block;
    logic                  has_word;
    logic                  has_sent;
    logic                  blk_is_bases;
    logic [SEQ_BITS-1:0]   blk_seq;
    logic [POS_BITS-1:0]   blk_seq_pos;
    logic [POS_BITS-1:0]   blk_offset;
    logic [BITPOS_W-1:0]   blk_bit_pos;
    logic [POS_BITS-1:0]   blk_length;
    logic [POS_BITS-1:0]   blk_base_total;
    logic [OUT_WORD_W-1:0] word;
    logic [FILL_W-1:0]     word_count;
    logic [POS_BITS-1:0]   tail_base_total;
    logic [POS_BITS-1:0]   sent_offset;
    logic [BITPOS_W-1:0]   sent_bit_pos;
    logic [CNT_BITS-1:0]   block_total;
  } cmd_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Classify a character: bit 2 set for a base, bits 1:0 its code
  function automatic logic [2:0] code_of(input logic [SYM_W-1:0] sym);
    logic [2:0] r;
    case (sym)
      SYM_UA, SYM_LA: r = 3'b100;
      SYM_UC, SYM_LC: r = 3'b101;
      SYM_UG, SYM_LG: r = 3'b110;
      SYM_UT, SYM_LT: r = 3'b111;
      default:        r = 3'b000;
    endcase
    return r;
  endfunction

  // Saturating increment of a position-sized counter
  function automatic logic [POS_BITS-1:0] sat_inc_pos(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

### src/nrbp_front.sv
// Front part: accepts characters and end items, tracks the open run and the
// partial packed word, and queues one command per item that causes results. Uses nrbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrbp_front
  import nrbp_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [119:0]   s_tdata,   // symbol, seq_id, pos_in_seq, str_pos
  input  wire logic [0:0]     s_tuser,   // kind
  input  wire q_stat_t        q_stat,
  output logic                push,
  output cmd_t                push_cmd
);

  in_t in_item;
  logic accept;

  // Run and packing state
  logic                 cur_is_bases, cur_is_bases_next;
  logic [SEQ_BITS-1:0]  cur_seq, cur_seq_next;
  logic [POS_BITS-1:0]  cur_seq_pos, cur_seq_pos_next;
  logic [POS_BITS-1:0]  cur_stream_offset, cur_stream_offset_next;
  logic [BITPOS_W-1:0]  cur_bit_pos, cur_bit_pos_next;
  logic [POS_BITS-1:0]  cur_length, cur_length_next;
  logic [POS_BITS-1:0]  bases_packed, bases_packed_next;
  logic [CNT_BITS-1:0]  blocks_emitted, blocks_emitted_next;
  logic [WORD_BITS-1:0] pack_buffer, pack_buffer_next;
  logic [FILL_W-1:0]    pack_fill, pack_fill_next;

  // Per-item derived values
  logic [2:0]           code_bits;
  logic                 is_base;
  logic [POS_BITS-1:0]  offset;
  logic [BITPOS_W-1:0]  bit_pos_now;
  logic [CNT_BITS-1:0]  blocks_inc;
  logic [WORD_BITS-1:0] insert_bits;
  logic [WORD_BITS-1:0] filled;
  logic [FILL_W-1:0]    fill_inc;

  assign in_item  = in_t'(s_tdata);
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // Classification and arithmetic shared by both item kinds
  always_comb begin
    code_bits   = code_of(in_item.symbol);
    is_base     = code_bits[2];
    offset      = (in_item.str_pos >= bases_packed) ? in_item.str_pos - bases_packed : '0;
    bit_pos_now = {bases_packed, 1'b0};
    blocks_inc  = (blocks_emitted == CNT_MAX) ? blocks_emitted : blocks_emitted + 1'b1;
    fill_inc    = pack_fill + 1'b1;
  end

  // Place the new code in the slot given by the fill count, first base in the top pair
  always_comb begin
    insert_bits = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pack_fill == FILL_W'(i)) begin
        insert_bits[WORD_BITS-1-2*i -: 2] = code_bits[1:0];
      end
    end
    filled = pack_buffer | insert_bits;
  end

  // Next state and the command for this item
  always_comb begin
    cur_is_bases_next      = cur_is_bases;
    cur_seq_next           = cur_seq;
    cur_seq_pos_next       = cur_seq_pos;
    cur_stream_offset_next = cur_stream_offset;
    cur_bit_pos_next       = cur_bit_pos;
    cur_length_next        = cur_length;
    bases_packed_next      = bases_packed;
    blocks_emitted_next    = blocks_emitted;
    pack_buffer_next       = pack_buffer;
    pack_fill_next         = pack_fill;
    push_cmd               = '0;

    // The open run is reported as it stands in every command
    push_cmd.blk_is_bases   = cur_is_bases;
    push_cmd.blk_seq        = cur_seq;
    push_cmd.blk_seq_pos    = cur_seq_pos;
    push_cmd.blk_offset     = cur_stream_offset;
    push_cmd.blk_bit_pos    = cur_bit_pos;
    push_cmd.blk_length     = cur_length;
    push_cmd.blk_base_total = bases_packed;

    if (accept) begin
      if (s_tuser[0] == KIND_CHAR) begin
        push_cmd.has_block = (cur_length != '0) && (is_base != cur_is_bases);
        if (push_cmd.has_block) begin
          blocks_emitted_next = blocks_inc;
        end

        // A type change or the very first character opens a new run
        if ((cur_length == '0) || (is_base != cur_is_bases)) begin
          cur_is_bases_next      = is_base;
          cur_seq_next           = in_item.seq_id;
          cur_seq_pos_next       = in_item.pos_in_seq;
          cur_stream_offset_next = offset;
          cur_bit_pos_next       = bit_pos_now;
          cur_length_next        = POS_BITS'(1);
        end else begin
          cur_length_next = sat_inc_pos(cur_length);
        end

        // Bases go into the pack buffer; a full word is sent out
        if (is_base) begin
          bases_packed_next = sat_inc_pos(bases_packed);
          if (fill_inc == FILL_W'(SLOTS)) begin
            push_cmd.has_word   = 1'b1;
            push_cmd.word       = OUT_WORD_W'(filled);
            push_cmd.word_count = fill_inc;
            pack_buffer_next    = '0;
            pack_fill_next      = '0;
          end else begin
            pack_buffer_next = filled;
            pack_fill_next   = fill_inc;
          end
        end

        push_cmd.tail_base_total = bases_packed_next;
        push_cmd.block_total     = blocks_emitted_next;
      end else begin
        // End of stream: last run, partial word, sentinel, then back to reset values
        push_cmd.has_block       = (cur_length != '0);
        push_cmd.has_word        = (pack_fill != '0);
        push_cmd.has_sent        = 1'b1;
        push_cmd.word            = OUT_WORD_W'(pack_buffer);
        push_cmd.word_count      = pack_fill;
        push_cmd.sent_offset     = offset;
        push_cmd.sent_bit_pos    = bit_pos_now;
        push_cmd.tail_base_total = bases_packed;
        push_cmd.block_total     = push_cmd.has_block ? blocks_inc : blocks_emitted;

        cur_is_bases_next      = 1'b0;
        cur_seq_next           = '0;
        cur_seq_pos_next       = '0;
        cur_stream_offset_next = '0;
        cur_bit_pos_next       = '0;
        cur_length_next        = '0;
        bases_packed_next      = '0;
        blocks_emitted_next    = '0;
        pack_buffer_next       = '0;
        pack_fill_next         = '0;
      end
    end

    push = accept && (push_cmd.has_block || push_cmd.has_word || push_cmd.has_sent);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_is_bases      <= 1'b0;
      cur_seq           <= '0;
      cur_seq_pos       <= '0;
      cur_stream_offset <= '0;
      cur_bit_pos       <= '0;
      cur_length        <= '0;
      bases_packed      <= '0;
      blocks_emitted    <= '0;
      pack_buffer       <= '0;
      pack_fill         <= '0;
    end else begin
      cur_is_bases      <= cur_is_bases_next;
      cur_seq           <= cur_seq_next;
      cur_seq_pos       <= cur_seq_pos_next;
      cur_stream_offset <= cur_stream_offset_next;
      cur_bit_pos       <= cur_bit_pos_next;
      cur_length        <= cur_length_next;
      bases_packed      <= bases_packed_next;
      blocks_emitted    <= blocks_emitted_next;
      pack_buffer       <= pack_buffer_next;
      pack_fill         <= pack_fill_next;
    end
  end

endmodule

`default_nettype wire

### src/nrbp_queue.sv
// Short command queue between the front and back parts of the packer.
// Four entries in flip-flops. Uses nrbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrbp_queue
  import nrbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   q_stat
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/nrbp_back.sv
// Back part: expands each queued command into its block record, packed word and sentinel
// results, one per cycle unless m_tready stalls, into the output register. Uses nrbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrbp_back
  import nrbp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmd_t     head,
  input  wire q_stat_t  q_stat,
  output logic          pop,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output logic [335:0]  m_tdata,   // packed_word, packed_count, block_is_bases, block_seq,
                                   // block_seq_pos, block_stream_offset, block_bit_pos,
                                   // block_length, base_total, block_total
  output logic [1:0]    m_tuser,   // result_kind
  output logic          m_tlast
);

  logic         blk_done, blk_done_next;
  logic         word_done, word_done_next;
  logic         load;
  logic         m_tvalid_next;
  res_t         res_sel;
  result_kind_t kind_sel;
  logic         last_sel;
  res_t         res_q;
  result_kind_t kind_q;
  logic         last_q;

  assign load = !q_stat.empty && (!m_tvalid || m_tready);

  // Pick the next result of the head command: block, then word, then sentinel
  always_comb begin
    res_sel             = '0;
    res_sel.block_total = head.block_total;
    kind_sel            = RK_SENT;
    last_sel            = 1'b1;
    blk_done_next       = blk_done;
    word_done_next      = word_done;
    if (head.has_block && !blk_done) begin
      kind_sel                    = RK_BLOCK;
      res_sel.block_is_bases      = head.blk_is_bases;
      res_sel.block_seq           = head.blk_seq;
      res_sel.block_seq_pos       = head.blk_seq_pos;
      res_sel.block_stream_offset = head.blk_offset;
      res_sel.block_bit_pos       = head.blk_bit_pos;
      res_sel.block_length        = head.blk_length;
      res_sel.base_total          = head.blk_base_total;
      last_sel                    = !(head.has_word || head.has_sent);
      blk_done_next               = 1'b1;
    end else if (head.has_word && !word_done) begin
      kind_sel             = RK_WORD;
      res_sel.packed_word  = head.word;
      res_sel.packed_count = head.word_count;
      res_sel.base_total   = head.tail_base_total;
      last_sel             = !head.has_sent;
      word_done_next       = 1'b1;
    end else begin
      res_sel.block_seq           = SEQ_ALL;
      res_sel.block_seq_pos       = POS_MAX;
      res_sel.block_stream_offset = head.sent_offset;
      res_sel.block_bit_pos       = head.sent_bit_pos;
      res_sel.base_total          = head.tail_base_total;
    end
    if (last_sel) begin
      blk_done_next  = 1'b0;
      word_done_next = 1'b0;
    end
    pop = load && last_sel;
  end

  // Output valid: set on a load, cleared when the result is taken
  always_comb begin
    if (load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      blk_done  <= 1'b0;
      word_done <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (load) begin
        blk_done  <= blk_done_next;
        word_done <= word_done_next;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      res_q  <= res_sel;
      kind_q <= kind_sel;
      last_q <= last_sel;
    end
  end

  assign m_tdata = res_q;
  assign m_tuser = kind_q;
  assign m_tlast = last_q;

endmodule

`default_nettype wire

### src/nucleotide_run_block_packer.sv
// Top level of the nucleotide run block packer: front part, command queue and back part.
// Depends on nrbp_pkg, nrbp_front, nrbp_queue and nrbp_back.
//
//   channel  direction  payload (tdata / tuser / tlast)
//   s_*      in         symbol, seq_id, pos_in_seq, str_pos / kind / -
//   m_*      out        result fields (336 bits) / result_kind / last
//
// One input item is taken per cycle while the four-entry command queue has room.
// A result passes through a queue entry and then the output register before it leaves.
// Each result takes one output cycle while m_tready is high, so an end item with a block,
// a word and a sentinel holds the back part until all three have left; the queue absorbs that.
// Reset clears all run and packing counters.
// Stalls on m_tready fill the queue and then drop s_tready.
`timescale 1ns / 1ps
`default_nettype none

module nucleotide_run_block_packer
  import nrbp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [119:0] s_tdata,   // symbol, seq_id, pos_in_seq, str_pos
  input  wire logic [0:0]   s_tuser,   // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [335:0]      m_tdata,   // packed_word, packed_count, block_is_bases, block_seq,
                                       // block_seq_pos, block_stream_offset, block_bit_pos,
                                       // block_length, base_total, block_total
  output logic [1:0]        m_tuser,   // result_kind
  output logic              m_tlast
);

  q_stat_t q_stat;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    head;

  // Classification and state update
  nrbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue
  nrbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Result sequencing and output register
  nrbp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### src/nrbp_checker.sv
// Port-level checks on the packer's output stream, bound to the top level.
// Depends on nrbp_pkg and nucleotide_run_block_packer.
`timescale 1ns / 1ps
`default_nettype none

module nrbp_checker
  import nrbp_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [335:0] m_tdata,
  input wire logic [1:0]   m_tuser,
  input wire logic         m_tlast
);

  res_t res;
  assign res = res_t'(m_tdata);

  // A stalled result holds still
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  // The sentinel always closes the results of its end item
  a_sent_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RK_SENT) |-> m_tlast)
    else $error("sentinel without last");

  // The sentinel carries all-ones start fields and no length
  a_sent_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RK_SENT) |-> (res.block_seq == SEQ_ALL)
      && (res.block_seq_pos == POS_MAX) && (res.block_length == '0))
    else $error("malformed sentinel");

  // A packed word holds between one and a full word of bases
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RK_WORD) |-> (res.packed_count != '0)
      && (res.packed_count <= FILL_W'(SLOTS)))
    else $error("bad packed word count");

endmodule

bind nucleotide_run_block_packer nrbp_checker u_nrbp_checker (.*);

`default_nettype wire

### dv/nucleotide_run_block_packer_test.sv
// Self-checking testbench for the nucleotide run block packer top level.
// Depends on nrbp_pkg and the nucleotide_run_block_packer RTL; predicts words, block
// records and sentinels in a local model and compares every result field by field.
`timescale 1ns / 1ps

module nucleotide_run_block_packer_test;
  import nrbp_pkg::*;

  localparam int unsigned ITEM_TARGET = 470;
  // No request on either side for this many cycles means the block is hung.
  // The longest correct quiet stretch is a sender gap plus a receiver stall.
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  // One expected result: kind on tuser, last on tlast, the rest on tdata.
  typedef struct packed {
    result_kind_t kind;
    logic         last;
    res_t         data;
  } packer_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [119:0]        s_tdata = '0;
  logic [0:0]          s_tuser = KIND_CHAR;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [335:0]        m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;

  // Local model of the run and packing state.
  logic                run_is_bases = 1'b0;
  logic [SEQ_BITS-1:0] run_seq = '0;
  logic [POS_BITS-1:0] run_seq_pos = '0;
  logic [POS_BITS-1:0] run_offset = '0;
  logic [BITPOS_W-1:0] run_bit_pos = '0;
  logic [POS_BITS-1:0] run_len = '0;
  logic [POS_BITS-1:0] base_count = '0;
  logic [CNT_BITS-1:0] block_count = '0;
  logic [WORD_BITS-1:0] word_buf = '0;
  logic [FILL_W-1:0]   word_fill = '0;

  packer_result_t      expected_results[$];

  int unsigned         items_sent = 0;
  int unsigned         ends_sent = 0;
  int unsigned         words_seen = 0;
  int unsigned         blocks_seen = 0;
  int unsigned         sentinels_seen = 0;
  int unsigned         mismatches = 0;
  int unsigned         burst_left = 0;
  int unsigned         sink_mode = 0;
  int unsigned         sink_phase_left = 0;

  nucleotide_run_block_packer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Returns 1 for A, C, G or T of either case, with its 2-bit code.
  function automatic logic base_code(input logic [SYM_W-1:0] sym, output logic [1:0] code);
    logic is_base;
    is_base = 1'b1;
    case (sym)
      SYM_UA, SYM_LA: code = 2'd0;
      SYM_UC, SYM_LC: code = 2'd1;
      SYM_UG, SYM_LG: code = 2'd2;
      SYM_UT, SYM_LT: code = 2'd3;
      default: begin
        code = 2'd0;
        is_base = 1'b0;
      end
    endcase
    return is_base;
  endfunction

  function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // Stream position less the bases packed so far, clamped at zero.
  function automatic logic [POS_BITS-1:0] stream_offset(input logic [POS_BITS-1:0] st);
    return (st >= base_count) ? st - base_count : '0;
  endfunction

  // Report of the open run; counts it toward the block total.
  function automatic packer_result_t close_run();
    packer_result_t r;
    if (block_count != CNT_MAX) block_count++;
    r = '0;
    r.kind = RK_BLOCK;
    r.data.block_is_bases = run_is_bases;
    r.data.block_seq = run_seq;
    r.data.block_seq_pos = run_seq_pos;
    r.data.block_stream_offset = run_offset;
    r.data.block_bit_pos = run_bit_pos;
    r.data.block_length = run_len;
    r.data.base_total = base_count;
    r.data.block_total = block_count;
    return r;
  endfunction

  function automatic packer_result_t word_result();
    packer_result_t r;
    r = '0;
    r.kind = RK_WORD;
    r.data.packed_word = word_buf;
    r.data.packed_count = word_fill;
    r.data.base_total = base_count;
    r.data.block_total = block_count;
    return r;
  endfunction

  // Works out the results of one accepted request and queues them in order.
  task automatic predict_item(input logic kind, input logic [SYM_W-1:0] sym,
                              input logic [SEQ_BITS-1:0] seq, input logic [POS_BITS-1:0] sp,
                              input logic [POS_BITS-1:0] st);
    packer_result_t step_results[$];
    packer_result_t r;
    logic           is_base;
    logic [1:0]     code;
    if (kind == KIND_CHAR) begin
      is_base = base_code(sym, code);
      // A change of run type reports the open run and starts a new one here.
      if (run_len == '0 || is_base != run_is_bases) begin
        if (run_len != '0) step_results.push_back(close_run());
        run_is_bases = is_base;
        run_seq = seq;
        run_seq_pos = sp;
        run_offset = stream_offset(st);
        run_bit_pos = {base_count, 1'b0};
        run_len = '0;
      end
      run_len = bump(run_len);
      // Bases fill the word from the top pair down.
      if (is_base) begin
        word_buf = word_buf | (WORD_BITS'(code) << (2 * (SLOTS - 1 - word_fill)));
        word_fill++;
        base_count = bump(base_count);
        if (word_fill == FILL_W'(SLOTS)) begin
          step_results.push_back(word_result());
          word_buf = '0;
          word_fill = '0;
        end
      end
    end else begin
      // End of stream: last run, partial word, then the totals.
      if (run_len != '0) step_results.push_back(close_run());
      if (word_fill != '0) step_results.push_back(word_result());
      r = '0;
      r.kind = RK_SENT;
      r.data.block_seq = SEQ_ALL;
      r.data.block_seq_pos = POS_MAX;
      r.data.block_stream_offset = stream_offset(st);
      r.data.block_bit_pos = {base_count, 1'b0};
      r.data.base_total = base_count;
      r.data.block_total = block_count;
      step_results.push_back(r);
      run_is_bases = 1'b0;
      run_seq = '0;
      run_seq_pos = '0;
      run_offset = '0;
      run_bit_pos = '0;
      run_len = '0;
      base_count = '0;
      block_count = '0;
      word_buf = '0;
      word_fill = '0;
    end
    if (step_results.size() != 0) step_results[$].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // Sends one request, in bursts of random length with random gaps between them.
  task automatic send_item(input logic kind, input logic [SYM_W-1:0] sym,
                           input logic [SEQ_BITS-1:0] seq, input logic [POS_BITS-1:0] sp,
                           input logic [POS_BITS-1:0] st);
    in_t         item;
    int unsigned pause;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (pause != 0) begin
        s_tvalid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
    burst_left--;
    item.symbol = sym;
    item.seq_id = seq;
    item.pos_in_seq = sp;
    item.str_pos = st;
    s_tdata <= item;
    s_tuser <= kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(kind, sym, seq, sp, st);
    items_sent++;
    if (kind == KIND_END) ends_sent++;
  endtask

  function automatic logic [POS_BITS-1:0] random_pos();
    return POS_BITS'({$urandom, $urandom});
  endfunction

  function automatic logic [SYM_W-1:0] random_base();
    logic [SYM_W-1:0] letters[8];
    letters = '{SYM_UA, SYM_UC, SYM_UG, SYM_UT, SYM_LA, SYM_LC, SYM_LG, SYM_LT};
    return letters[$urandom_range(0, 7)];
  endfunction

  // Half the time N, n or dash; otherwise any byte that is not a base.
  function automatic logic [SYM_W-1:0] random_gap();
    logic [SYM_W-1:0] sym;
    logic [1:0]       code;
    case ($urandom_range(0, 5))
      0: sym = 8'h4E;
      1: sym = 8'h6E;
      2: sym = 8'h2D;
      default: begin
        sym = SYM_W'($urandom);
        while (base_code(sym, code)) sym = SYM_W'($urandom);
      end
    endcase
    return sym;
  endfunction

  // An end with nothing before it gives a sentinel alone.
  task automatic test_empty_stream();
    send_item(KIND_END, 8'h00, '0, '0, '0);
  endtask

  // All-zero and all-one fields, a base run closed by a gap and a flushed partial word.
  task automatic test_field_extremes();
    send_item(KIND_CHAR, SYM_UA, '0, '0, '0);
    send_item(KIND_CHAR, SYM_LT, SEQ_ALL, POS_MAX, POS_MAX);
    send_item(KIND_CHAR, 8'hFF, SEQ_ALL, POS_MAX, POS_MAX);
    send_item(KIND_CHAR, 8'h00, '0, '0, '0);
    send_item(KIND_END, 8'hFF, SEQ_ALL, POS_MAX, POS_MAX);
  endtask

  // Leading gap, every base letter, and stream positions behind the base count.
  task automatic test_symbol_set();
    logic [SYM_W-1:0] letters[8];
    letters = '{SYM_UA, SYM_UC, SYM_UG, SYM_UT, SYM_LA, SYM_LC, SYM_LG, SYM_LT};
    send_item(KIND_CHAR, 8'h4E, 32'd7, '0, '0);
    foreach (letters[i]) send_item(KIND_CHAR, letters[i], 32'd7, 40'(i + 1), 40'(i + 1));
    send_item(KIND_CHAR, 8'h2D, 32'd7, 40'd9, 40'd3);
    send_item(KIND_CHAR, SYM_LA, 32'd8, '0, 40'd1);
    send_item(KIND_END, 8'h00, '0, '0, 40'd2);
  endtask

  // A full word and a run change on the same character: record first, then the word.
  task automatic test_word_at_run_change();
    logic [SEQ_BITS-1:0] seq;
    logic [POS_BITS-1:0] pos;
    seq = $urandom;
    pos = random_pos();
    for (int unsigned i = 0; i < SLOTS - 1; i++) begin
      send_item(KIND_CHAR, random_base(), seq, pos, pos);
      pos++;
    end
    send_item(KIND_CHAR, random_gap(), seq, pos, pos);
    pos++;
    send_item(KIND_CHAR, random_base(), seq, pos, pos);
    pos++;
    send_item(KIND_END, SYM_W'($urandom), $urandom, random_pos(), pos);
  endtask

  // One stream of alternating base and gap runs, with a little noise mixed in.
  task automatic send_stream(input int unsigned length);
    logic [SEQ_BITS-1:0] seq;
    logic [POS_BITS-1:0] sp;
    logic [POS_BITS-1:0] st;
    logic                in_bases;
    int unsigned         run_left;
    seq = $urandom;
    sp = $urandom_range(0, 1) ? '0 : random_pos();
    st = ($urandom_range(0, 3) == 0) ? random_pos() : POS_BITS'($urandom_range(0, 64));
    in_bases = $urandom_range(0, 1);
    run_left = 0;
    for (int unsigned i = 0; i < length; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item(1'($urandom), SYM_W'($urandom), $urandom, random_pos(), random_pos());
        continue;
      end
      if (run_left == 0) begin
        in_bases = !in_bases;
        run_left = in_bases ? $urandom_range(1, 40) : $urandom_range(1, 6);
      end
      run_left--;
      if ($urandom_range(0, 49) == 0) begin
        seq = seq + 1'b1;
        sp = '0;
      end
      send_item(KIND_CHAR, in_bases ? random_base() : random_gap(), seq, sp, st);
      sp++;
      st++;
    end
    send_item(KIND_END, SYM_W'($urandom), $urandom, random_pos(), st);
  endtask

  task automatic test_random_streams();
    int unsigned length;
    while (items_sent < ITEM_TARGET) begin
      length = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 40);
      send_stream(length);
    end
  endtask

  // Receiver readiness: phases of full speed, light and heavy random stalls, long stalls.
  always @(posedge clk) begin : sink_pattern
    if (sink_phase_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_phase_left <= $urandom_range(16, 96);
    end else begin
      sink_phase_left <= sink_phase_left - 1;
    end
    case (sink_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= 1'($urandom);
      default: m_tready <= (sink_phase_left[3:0] < 4'd3);
    endcase
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Each accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    packer_result_t want;
    res_t           got;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata);
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("%0t: result with nothing expected, kind %0d", $time, m_tuser);
      end else begin
        want = expected_results.pop_front();
        case (want.kind)
          RK_WORD:  words_seen++;
          RK_BLOCK: blocks_seen++;
          default:  sentinels_seen++;
        endcase
        compare_field("result_kind", want.kind, m_tuser);
        compare_field("last", want.last, m_tlast);
        compare_field("packed_word", want.data.packed_word, got.packed_word);
        compare_field("packed_count", want.data.packed_count, got.packed_count);
        compare_field("block_is_bases", want.data.block_is_bases, got.block_is_bases);
        compare_field("block_seq", want.data.block_seq, got.block_seq);
        compare_field("block_seq_pos", want.data.block_seq_pos, got.block_seq_pos);
        compare_field("block_stream_offset", want.data.block_stream_offset,
                      got.block_stream_offset);
        compare_field("block_bit_pos", want.data.block_bit_pos, got.block_bit_pos);
        compare_field("block_length", want.data.block_length, got.block_length);
        compare_field("base_total", want.data.base_total, got.base_total);
        compare_field("block_total", want.data.block_total, got.block_total);
      end
    end
  end

  // Ends the run if no request moves on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
    $display("nucleotide_run_block_packer_test: done, errors");
    $finish;
  end

  initial begin : main_sequence
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stream();
    test_field_extremes();
    test_symbol_set();
    test_word_at_run_change();
    test_random_streams();
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    $display("Sent %0d requests in %0d streams; checked %0d words, %0d block records,",
             items_sent, ends_sent, words_seen, blocks_seen);
    $display("%0d sentinels; %0d field mismatches.", sentinels_seen, mismatches);
    if (mismatches == 0) begin
      $display("nucleotide_run_block_packer_test: done, clean");
    end else begin
      $display("nucleotide_run_block_packer_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/nrbp_pkg.sv
src/nrbp_front.sv
src/nrbp_queue.sv
src/nrbp_back.sv
src/nucleotide_run_block_packer.sv
src/nrbp_checker.sv
dv/nucleotide_run_block_packer_test.sv
